@@ src/ssph_pkg.sv @@
// ----------------------------------------------------------------------------
// ssph_pkg
// Shared types, constants and helpers for the UV sphere tessellator.
// ----------------------------------------------------------------------------
package ssph_pkg;

   localparam int CNT_W   = 11;
   localparam int IDX_W   = 10;
   localparam int NUM_W   = 14;
   localparam int RAD_W   = 16;
   localparam int COORD_W = 17;
   localparam int TRIG_W  = 18;
   localparam int SLOT_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIVD_W = 42;
   localparam int QUO_W  = 31;
   localparam int DVS_W  = 11;

   // usable count limits; the count registers are CNT_W bits wide
   localparam int MAX_SLICES = 1024;
   localparam int MAX_STACKS = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STACKS = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;
   localparam logic [CNT_W-1:0] SLICES_RESET = 11'd16;
   localparam logic [CNT_W-1:0] STACKS_RESET = 11'd16;

   localparam logic [QUO_W-1:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [QUO_W-1:0] Q30_ONE     = 31'd1073741824;
   localparam logic [16:0]      TRIG_ONE    = 17'd65536;
   localparam logic [SLOT_W-1:0] LAST_SLOT  = 3'd5;

   typedef struct packed {
      logic             cap;
      logic [NUM_W-1:0] lat0;
      logic [NUM_W-1:0] lat1;
      logic [NUM_W-1:0] lon0;
      logic [NUM_W-1:0] lon1;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [CNT_W-1:0] den;
   } trig_req_type;

   // divide by 2^pre * odd: shift out the power of two, then multiply by
   // ceil(2^post / odd) and shift; exact for 31-bit dividends
   typedef struct packed {
      logic [1:0]  pre;
      logic [31:0] mul;
      logic [5:0]  post;
   } recip_type;

   // Taylor divisors 156, 110, 72, 42, 20, 6, innermost term first
   function automatic recip_type taylor_recip(input logic [2:0] k);
      recip_type r;
      unique case (k)
         3'd0:    r = '{2'd2, 32'd3524075731, 6'd37};
         3'd1:    r = '{2'd1, 32'd2498890064, 6'd37};
         3'd2:    r = '{2'd3, 32'd3817748708, 6'd35};
         3'd3:    r = '{2'd1, 32'd3272356036, 6'd36};
         3'd4:    r = '{2'd2, 32'd3435973837, 6'd34};
         default: r = '{2'd1, 32'd2863311531, 6'd33};
      endcase
      return r;
   endfunction

   function automatic logic is_pole(input logic cap, input logic [SLOT_W-1:0] k);
      return cap && (k == 3'd0 || k == 3'd3);
   endfunction

   // latitude entry used by a vertex slot: 0 = upper/cap, 1 = lower/negative cap
   function automatic logic lat_sel(input logic cap, input logic [SLOT_W-1:0] k);
      logic s;
      if (cap) begin
         s = (k == 3'd4 || k == 3'd5);
      end else begin
         s = (k == 3'd1 || k == 3'd4 || k == 3'd5);
      end
      return s;
   endfunction

   function automatic logic lon_sel(input logic cap, input logic [SLOT_W-1:0] k);
      logic s;
      if (cap) begin
         s = (k == 3'd2 || k == 3'd4);
      end else begin
         s = (k == 3'd2 || k == 3'd3 || k == 3'd5);
      end
      return s;
   endfunction

   // round to nearest, halves away from zero, then keep 17 bits
   function automatic logic [COORD_W-1:0] round_q32(input logic signed [52:0] p);
      logic        neg;
      logic [52:0] mag;
      neg = p[52];
      mag = neg ? 53'(-p) : 53'(p);
      mag = (mag + (53'd1 << 31)) >> 32;
      return neg ? COORD_W'(-mag) : COORD_W'(mag);
   endfunction

   function automatic logic [COORD_W-1:0] round_q16(input logic signed [34:0] p);
      logic        neg;
      logic [34:0] mag;
      neg = p[34];
      mag = neg ? 35'(-p) : 35'(p);
      mag = (mag + (35'd1 << 15)) >> 16;
      return neg ? COORD_W'(-mag) : COORD_W'(mag);
   endfunction

endpackage

@@ src/ssph_div.sv @@
// ----------------------------------------------------------------------------
// ssph_div
// Restoring divider, one quotient bit per cycle, 31 quotient bits.
// ----------------------------------------------------------------------------
module ssph_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ssph_pkg::DIVD_W-1:0]  dividend,
   input  logic [ssph_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [ssph_pkg::QUO_W-1:0]   quotient
);
   import ssph_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [QUO_W-1:0]    work_ff, work_in;
   logic [DVS_W:0]      cand;
   logic                ge;

   // upper dividend bits are always below the divisor
   always_comb begin
      cand    = {rem_ff, work_ff[QUO_W-1]};
      ge      = cand >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      work_in = work_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[DIVD_W-1:QUO_W];
         work_in = dividend[QUO_W-1:0];
         dvs_in  = divisor;
      end else if (run_ff) begin
         rem_in  = ge ? DVS_W'(cand - {1'b0, dvs_ff}) : cand[DVS_W-1:0];
         work_in = {work_ff[QUO_W-2:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(QUO_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      work_ff <= work_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

@@ src/ssph_trig.sv @@
// ----------------------------------------------------------------------------
// ssph_trig
// Sine of num/den quarter turns in signed Q16: quadrant fold, angle divide on
// a sequential divider, Horner Taylor series by reciprocal multiplication.
// ----------------------------------------------------------------------------
module ssph_trig (
   input  logic                          clock,
   input  logic                          reset,
   input  ssph_pkg::trig_req_type        req,
   output logic                          done,
   output logic signed [ssph_pkg::TRIG_W-1:0] value
);
   import ssph_pkg::*;

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_QUAD = 3'd1;
   localparam logic [2:0] T_MUL  = 3'd2;
   localparam logic [2:0] T_XDIV = 3'd3;
   localparam logic [2:0] T_X2   = 3'd4;
   localparam logic [2:0] T_TMUL = 3'd5;
   localparam logic [2:0] T_TDIV = 3'd6;
   localparam logic [2:0] T_FIN  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [NUM_W-1:0]  red_ff, red_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  m_ff, m_in;
   logic              neg_ff, neg_in;
   logic [QUO_W-1:0]  x_ff, x_in;
   logic [31:0]       x2_ff, x2_in;
   logic [QUO_W-1:0]  t_ff, t_in;
   logic [QUO_W-1:0]  a_ff, a_in;
   logic [2:0]        k_ff, k_in;
   logic              done_ff, done_in;
   logic signed [TRIG_W-1:0] val_ff, val_in;

   logic              div_start;
   logic [DIVD_W-1:0] div_dividend;
   logic [DVS_W-1:0]  div_divisor;
   logic              div_done;
   logic [QUO_W-1:0]  div_quo;

   logic [NUM_W-1:0]  den4, den_n, den2, den3, rem_n;
   logic [1:0]        quad;
   logic [61:0]       xx, xt;
   logic [62:0]       x2t;
   logic [18:0]       vr;
   logic [16:0]       vc;
   recip_type         rc;
   logic [62:0]       aq;
   logic [QUO_W-1:0]  quo_t;

   ssph_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      den4  = NUM_W'(req.den) << 2;
      den_n = NUM_W'(den_ff);
      den2  = den_n << 1;
      den3  = den2 + den_n;
      priority if (red_ff >= den3) begin
         quad  = 2'd3;
         rem_n = red_ff - den3;
      end else if (red_ff >= den2) begin
         quad  = 2'd2;
         rem_n = red_ff - den2;
      end else if (red_ff >= den_n) begin
         quad  = 2'd1;
         rem_n = red_ff - den_n;
      end else begin
         quad  = 2'd0;
         rem_n = red_ff;
      end
      xx  = 62'(x_ff) * 62'(x_ff);
      x2t = 63'(x2_ff) * 63'(t_ff);
      xt  = 62'(x_ff) * 62'(t_ff);
      vr  = 19'((33'(xt[61:30]) + 33'd8192) >> 14);
      vc  = (vr > 19'(TRIG_ONE)) ? TRIG_ONE : vr[16:0];
      rc    = taylor_recip(k_ff);
      aq    = 63'(a_ff) * 63'(rc.mul);
      quo_t = QUO_W'(aq >> rc.post);

      state_in = state_ff;
      red_in   = red_ff;
      den_in   = den_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      a_in     = a_ff;
      k_in     = k_ff;
      done_in  = 1'b0;
      val_in   = val_ff;
      div_start    = 1'b0;
      div_dividend = 42'(HALF_PI_Q30) * 42'(m_ff) + 42'(den_ff >> 1);
      div_divisor  = den_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (req.start) begin
               red_in   = (req.num >= den4) ? req.num - den4 : req.num;
               den_in   = req.den;
               state_in = T_QUAD;
            end
         end
         T_QUAD: begin
            m_in     = quad[0] ? CNT_W'(den_n - rem_n) : CNT_W'(rem_n);
            neg_in   = quad[1];
            state_in = T_MUL;
         end
         T_MUL: begin
            div_start = 1'b1;
            state_in  = T_XDIV;
         end
         T_XDIV: begin
            if (div_done) begin
               x_in     = div_quo;
               state_in = T_X2;
            end
         end
         T_X2: begin
            x2_in    = xx[61:30];
            t_in     = Q30_ONE;
            k_in     = '0;
            state_in = T_TMUL;
         end
         T_TMUL: begin
            a_in     = QUO_W'(x2t[62:30] >> rc.pre);
            state_in = T_TDIV;
         end
         T_TDIV: begin
            t_in = Q30_ONE - quo_t;
            if (k_ff == 3'd5) begin
               state_in = T_FIN;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = T_TMUL;
            end
         end
         T_FIN: begin
            val_in   = neg_ff ? -TRIG_W'(vc) : TRIG_W'(vc);
            done_in  = 1'b1;
            state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      red_ff <= red_in;
      den_ff <= den_in;
      m_ff   <= m_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      x2_ff  <= x2_in;
      t_ff   <= t_in;
      a_ff   <= a_in;
      k_ff   <= k_in;
      val_ff <= val_in;
   end

   assign done  = done_ff;
   assign value = val_ff;

endmodule

@@ src/ssph_queue.sv @@
// ----------------------------------------------------------------------------
// ssph_queue
// Two-entry queue of classified cell items between front and back.
// ----------------------------------------------------------------------------
module ssph_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssph_pkg::item_type push_item,
   input  logic               pop,
   output ssph_pkg::item_type head,
   output logic               full,
   output logic               empty
);
   import ssph_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop  ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign head  = mem_ff[rd_ff];
   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;

endmodule

@@ src/ssph_front.sv @@
// ----------------------------------------------------------------------------
// ssph_front
// Accepts cell requests, clamps indices and forms the angle numerators.
// ----------------------------------------------------------------------------
module ssph_front (
   input  logic                        start,
   output logic                        busy,
   input  logic [ssph_pkg::IDX_W-1:0]  slice_index,
   input  logic [ssph_pkg::IDX_W-1:0]  band_index,
   input  logic [ssph_pkg::CNT_W-1:0]  slices,
   input  logic [ssph_pkg::CNT_W-1:0]  stacks,
   input  logic                        q_full,
   output logic                        push,
   output ssph_pkg::item_type          item
);
   import ssph_pkg::*;

   logic [CNT_W-1:0] i_max, j_max, i_c, j_c;
   logic [NUM_W-1:0] st5, side_top;

   always_comb begin
      i_max    = slices - CNT_W'(1);
      j_max    = stacks - CNT_W'(2);
      i_c      = (CNT_W'(slice_index) > i_max) ? i_max : CNT_W'(slice_index);
      j_c      = (CNT_W'(band_index) > j_max) ? j_max : CNT_W'(band_index);
      st5      = (NUM_W'(stacks) << 2) + NUM_W'(stacks);
      side_top = st5 - (NUM_W'(j_c) << 1);
      item.cap = j_c == '0;
      if (item.cap) begin
         item.lat0 = st5 - NUM_W'(2);
         item.lat1 = (NUM_W'(stacks) << 1) + NUM_W'(stacks) + NUM_W'(2);
      end else begin
         item.lat0 = side_top;
         item.lat1 = side_top - NUM_W'(2);
      end
      item.lon0 = NUM_W'(i_c) << 2;
      item.lon1 = NUM_W'(i_c + CNT_W'(1)) << 2;
   end

   assign busy = q_full;
   assign push = start && !q_full;

endmodule

@@ src/ssph_back.sv @@
// ----------------------------------------------------------------------------
// ssph_back
// Runs the eight sines and cosines of a cell, then emits its six vertices.
// ----------------------------------------------------------------------------
module ssph_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  ssph_pkg::item_type                q_head,
   output logic                              q_pop,
   input  logic [ssph_pkg::RAD_W-1:0]        radius,
   input  logic [ssph_pkg::CNT_W-1:0]        slices,
   input  logic [ssph_pkg::CNT_W-1:0]        stacks,
   output logic                              rsp_valid,
   output logic signed [ssph_pkg::COORD_W-1:0] rsp_pos_x,
   output logic signed [ssph_pkg::COORD_W-1:0] rsp_pos_y,
   output logic signed [ssph_pkg::COORD_W-1:0] rsp_pos_z,
   output logic [ssph_pkg::SLOT_W-1:0]       rsp_vertex_slot,
   output logic                              rsp_last
);
   import ssph_pkg::*;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_TRIG  = 3'd1;
   localparam logic [2:0] B_TWAIT = 3'd2;
   localparam logic [2:0] B_V1    = 3'd3;
   localparam logic [2:0] B_V2    = 3'd4;
   localparam logic [2:0] B_V3    = 3'd5;

   logic [2:0]        state_ff, state_in;
   item_type          item_ff, item_in;
   logic [2:0]        tidx_ff, tidx_in;
   logic [SLOT_W-1:0] k_ff, k_in;

   logic signed [TRIG_W-1:0] lat_sin_ff [2];
   logic signed [TRIG_W-1:0] lat_cos_ff [2];
   logic signed [TRIG_W-1:0] lon_sin_ff [2];
   logic signed [TRIG_W-1:0] lon_cos_ff [2];

   logic signed [34:0] rcb_ff, ry_ff;
   logic signed [52:0] px_ff, pz_ff;

   logic                     valid_ff, valid_in;
   logic [COORD_W-1:0]       x_ff, y_ff, z_ff;
   logic [COORD_W-1:0]       x_in, y_in, z_in;
   logic [SLOT_W-1:0]        slot_ff;
   logic                     last_ff;

   trig_req_type             treq;
   logic                     tdone;
   logic signed [TRIG_W-1:0] tval;
   logic [NUM_W-1:0]         tbase;
   logic                     lsel, osel;
   logic signed [34:0]       r_s;
   logic [COORD_W-1:0]       r_u;

   ssph_trig u_trig (
      .clock (clock),
      .reset (reset),
      .req   (treq),
      .done  (tdone),
      .value (tval)
   );

   always_comb begin
      // trig index: bit 2 longitude, bit 1 entry, bit 0 cosine
      unique case (tidx_ff[2:1])
         2'd0:    tbase = item_ff.lat0;
         2'd1:    tbase = item_ff.lat1;
         2'd2:    tbase = item_ff.lon0;
         default: tbase = item_ff.lon1;
      endcase
      treq.start = state_ff == B_TRIG;
      treq.den   = tidx_ff[2] ? slices : stacks;
      treq.num   = tbase + (tidx_ff[0] ? NUM_W'(treq.den) : '0);

      lsel = lat_sel(item_ff.cap, k_ff);
      osel = lon_sel(item_ff.cap, k_ff);
      r_u  = COORD_W'(radius);
      r_s  = 35'(signed'(r_u));

      state_in = state_ff;
      item_in  = item_ff;
      tidx_in  = tidx_ff;
      k_in     = k_ff;
      q_pop    = 1'b0;
      valid_in = 1'b0;
      x_in     = '0;
      z_in     = '0;
      y_in     = round_q16(ry_ff);

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               tidx_in  = '0;
               state_in = B_TRIG;
            end
         end
         B_TRIG: state_in = B_TWAIT;
         B_TWAIT: begin
            if (tdone) begin
               if (tidx_ff == 3'd7) begin
                  k_in     = '0;
                  state_in = B_V1;
               end else begin
                  tidx_in  = tidx_ff + 3'd1;
                  state_in = B_TRIG;
               end
            end
         end
         B_V1: state_in = B_V2;
         B_V2: state_in = B_V3;
         B_V3: begin
            valid_in = 1'b1;
            if (is_pole(item_ff.cap, k_ff)) begin
               y_in = (k_ff == '0) ? r_u : COORD_W'(-r_u);
            end else begin
               x_in = round_q32(px_ff);
               z_in = round_q32(pz_ff);
            end
            if (k_ff == LAST_SLOT) begin
               state_in = B_IDLE;
            end else begin
               k_in     = k_ff + SLOT_W'(1);
               state_in = B_V1;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
      tidx_ff <= tidx_in;
      k_ff    <= k_in;
      if (state_ff == B_TWAIT && tdone) begin
         unique case ({tidx_ff[2], tidx_ff[0]})
            2'b00:   lat_sin_ff[tidx_ff[1]] <= tval;
            2'b01:   lat_cos_ff[tidx_ff[1]] <= tval;
            2'b10:   lon_sin_ff[tidx_ff[1]] <= tval;
            default: lon_cos_ff[tidx_ff[1]] <= tval;
         endcase
      end
      if (state_ff == B_V1) begin
         rcb_ff <= r_s * 35'(lat_cos_ff[lsel]);
         ry_ff  <= r_s * 35'(lat_sin_ff[lsel]);
      end
      if (state_ff == B_V2) begin
         px_ff <= 53'(rcb_ff) * 53'(lon_sin_ff[osel]);
         pz_ff <= 53'(rcb_ff) * 53'(lon_cos_ff[osel]);
      end
      if (state_ff == B_V3) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         slot_ff <= k_ff;
         last_ff <= k_ff == LAST_SLOT;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pos_x       = x_ff;
   assign rsp_pos_y       = y_ff;
   assign rsp_pos_z       = z_ff;
   assign rsp_vertex_slot = slot_ff;
   assign rsp_last        = last_ff;

endmodule

@@ src/uv_sphere_tessellator.sv @@
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// One UV sphere cell per request, six vertices out, one per strobe.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) names a slice and a band; the six
// vertices of that cell come out on rsp_valid strobes, slot 0 to 5, with
// rsp_last on slot 5. Results cannot be held off. For each cell the block
// takes it from the queue, runs eight sines and cosines (each a bit-serial
// angle divide plus six Taylor steps done by reciprocal multiplication),
// then forms and strobes the six vertices one after another. A two-entry
// queue lets two further requests be taken while a cell is in progress;
// busy is high while that queue is full.
module uv_sphere_tessellator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ssph_pkg::IDX_W-1:0]           req_slice_index,
   input  logic [ssph_pkg::IDX_W-1:0]           req_band_index,
   output logic                                 rsp_valid,
   output logic signed [ssph_pkg::COORD_W-1:0]  rsp_pos_x,
   output logic signed [ssph_pkg::COORD_W-1:0]  rsp_pos_y,
   output logic signed [ssph_pkg::COORD_W-1:0]  rsp_pos_z,
   output logic [ssph_pkg::SLOT_W-1:0]          rsp_vertex_slot,
   output logic                                 rsp_last,
   input  logic                                 csr_write_en,
   input  logic [ssph_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssph_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ssph_pkg::*;

   logic [RAD_W-1:0] radius_ff;
   logic [CNT_W-1:0] slices_ff, stacks_ff;
   logic [CNT_W-1:0] slices_eff, stacks_eff;
   logic             q_full, q_empty, q_push, q_pop;
   item_type         f_item, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         slices_ff <= SLICES_RESET;
         stacks_ff <= STACKS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_SLICES: slices_ff <= csr_data[CNT_W-1:0];
            CSR_STACKS: stacks_ff <= csr_data[CNT_W-1:0];
            default:    ;
         endcase
      end
   end

   // clamp counts to the usable range
   always_comb begin
      if (slices_ff == '0) begin
         slices_eff = CNT_W'(1);
      end else if (32'(slices_ff) > MAX_SLICES) begin
         slices_eff = CNT_W'(MAX_SLICES);
      end else begin
         slices_eff = slices_ff;
      end
      if (stacks_ff < CNT_W'(2)) begin
         stacks_eff = CNT_W'(2);
      end else if (32'(stacks_ff) > MAX_STACKS) begin
         stacks_eff = CNT_W'(MAX_STACKS);
      end else begin
         stacks_eff = stacks_ff;
      end
   end

   ssph_front u_front (
      .start       (start),
      .busy        (busy),
      .slice_index (req_slice_index),
      .band_index  (req_band_index),
      .slices      (slices_eff),
      .stacks      (stacks_eff),
      .q_full      (q_full),
      .push        (q_push),
      .item        (f_item)
   );

   ssph_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (f_item),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   ssph_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .radius          (radius_ff),
      .slices          (slices_eff),
      .stacks          (stacks_eff),
      .rsp_valid       (rsp_valid),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_vertex_slot (rsp_vertex_slot),
      .rsp_last        (rsp_last)
   );

endmodule
